// ===== rtl/ranging_bit_sequencer_core_defines.svh =====
// Assertion macros shared by the ranging bit sequencer checker.
// Needs a clk and an rst signal in the scope where a macro is used.
`ifndef RANGING_BIT_SEQUENCER_CORE_DEFINES_SVH
`define RANGING_BIT_SEQUENCER_CORE_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define RBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define RBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/rbs_pkg.sv =====
// Shared types and constants for the ranging bit sequencer.
// No dependencies.
package rbs_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;
  localparam int unsigned TimeWidth     = 32;

  // Configuration register indexes
  localparam logic [CfgIndexWidth-1:0] REG_SYNC_PATTERN    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_FRAME_BITS      = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_ACK_POSITION    = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_ZERO_RUN_LENGTH = 2'd3;

  localparam logic [7:0] SYNC_PATTERN_RESET    = 8'h72;
  localparam logic [5:0] FRAME_BITS_RESET      = 6'd37;
  localparam logic [5:0] ACK_POSITION_RESET    = 6'd16;
  localparam logic [5:0] ZERO_RUN_LENGTH_RESET = 6'd20;
  localparam logic [7:0] SYNC_SHIFT_RESET      = 8'hFF;
  localparam logic [5:0] ZERO_COUNT_MAX        = 6'h3F;

  localparam logic [1:0] STAGE_INITIAL  = 2'd0;
  localparam logic [1:0] STAGE_ACKED    = 2'd1;
  localparam logic [1:0] STAGE_REVERSED = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FRAME = 3'd1,
    PH_ZEROA = 3'd2,
    PH_ONEA  = 3'd3,
    PH_ZEROB = 3'd4,
    PH_ONEB  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] sync_pattern;
    logic [5:0] frame_bits;
    logic [5:0] ack_position;
    logic [5:0] zero_run_length;
  } cfg_t;

  // One decoded bit on its way from the front to the sequencer
  typedef struct packed {
    logic                 decoded_bit;
    logic [TimeWidth-1:0] sample_time;
  } item_t;

  typedef struct packed {
    logic                 decoded_bit;
    logic [2:0]           phase;
    logic [1:0]           tx_stage;
    logic                 frame_done;
    logic                 frame_ack;
    logic                 round_trip_valid;
    logic [TimeWidth-1:0] round_trip;
  } result_t;

endpackage

// ===== rtl/rbs_front.sv =====
// Front end: accepts decision beats and differentially decodes them.
// Depends on rbs_pkg.
module rbs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            raw_decision,
  input  logic [rbs_pkg::TimeWidth-1:0]   sample_time,
  input  logic                            q_full,
  output logic                            push,
  output rbs_pkg::item_t                  push_item
);

  logic previous_decision;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign push_item.decoded_bit = raw_decision ^ previous_decision;
  assign push_item.sample_time = sample_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_decision <= 1'b0;
    end else if (push) begin
      previous_decision <= raw_decision;
    end
  end

endmodule

// ===== rtl/rbs_queue.sv =====
// Two-entry queue between the decode front end and the sequencer.
// Depends on rbs_pkg.
module rbs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rbs_pkg::item_t push_item,
  output logic           full,
  output logic           q_valid,
  output rbs_pkg::item_t q_item,
  input  logic           pop
);

  rbs_pkg::item_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/rbs_seq.sv =====
// Back end: sync hunt, frame collection and reversal timing, with the
// output register. Depends on rbs_pkg.
module rbs_seq (
  input  logic              clk,
  input  logic              rst,
  input  rbs_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  rbs_pkg::item_t    q_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rbs_pkg::result_t  result
);

  rbs_pkg::phase_t              phase, phase_next;
  logic [7:0]                   sync_shift, sync_shift_next;
  logic [5:0]                   frame_index, frame_index_next;
  logic                         ack_latch, ack_latch_next;
  logic [5:0]                   zero_count, zero_count_next;
  logic [rbs_pkg::TimeWidth-1:0] first_time, first_time_next;

  logic                         b;
  logic [rbs_pkg::TimeWidth-1:0] t;
  logic [7:0]                   shifted;
  logic                         sync_held;
  logic [5:0]                   fi_base;
  logic                         ack_base;
  logic                         ack_new;
  logic [5:0]                   fi_inc;
  logic                         frame_end;
  logic                         run_met;
  logic [5:0]                   zc_new;
  rbs_pkg::result_t             res_next;

  assign pop = q_valid && (!out_valid || out_ready);
  assign b   = q_item.decoded_bit;
  assign t   = q_item.sample_time;

  // Frame step, shared by the frame phase and a hunt whose sync already matches
  assign shifted   = {sync_shift[6:0], b};
  assign sync_held = (phase == rbs_pkg::PH_HUNT);
  assign fi_base   = sync_held ? 6'd0 : frame_index;
  assign ack_base  = sync_held ? 1'b0 : ack_latch;
  assign ack_new   = (fi_base == cfg.ack_position) ? b : ack_base;
  assign fi_inc    = fi_base + 6'd1;
  assign frame_end = (fi_inc >= cfg.frame_bits);

  // Zero-run step for either zeros phase
  assign run_met = (zero_count >= cfg.zero_run_length);
  assign zc_new  = b ? 6'd0
                 : ((zero_count != rbs_pkg::ZERO_COUNT_MAX) ? zero_count + 6'd1 : zero_count);

  always_comb begin
    phase_next       = phase;
    sync_shift_next  = sync_shift;
    frame_index_next = frame_index;
    ack_latch_next   = ack_latch;
    zero_count_next  = zero_count;
    first_time_next  = first_time;
    res_next         = '0;
    res_next.decoded_bit = b;

    unique case (phase)
      rbs_pkg::PH_HUNT, rbs_pkg::PH_FRAME: begin
        if (phase == rbs_pkg::PH_HUNT && sync_shift != cfg.sync_pattern) begin
          sync_shift_next = shifted;
          if (shifted == cfg.sync_pattern) begin
            phase_next       = rbs_pkg::PH_FRAME;
            frame_index_next = 6'd0;
            ack_latch_next   = 1'b0;
          end
        end else begin
          phase_next       = rbs_pkg::PH_FRAME;
          ack_latch_next   = ack_new;
          frame_index_next = fi_inc;
          if (frame_end) begin
            res_next.frame_done = 1'b1;
            res_next.frame_ack  = ack_new;
            if (ack_new) begin
              phase_next      = rbs_pkg::PH_ZEROA;
              zero_count_next = 6'd0;
            end else begin
              phase_next      = rbs_pkg::PH_HUNT;
              sync_shift_next = rbs_pkg::SYNC_SHIFT_RESET;
            end
          end
        end
      end
      rbs_pkg::PH_ZEROA, rbs_pkg::PH_ONEA: begin
        if (phase == rbs_pkg::PH_ZEROA && !run_met) begin
          zero_count_next = zc_new;
          if (zc_new >= cfg.zero_run_length) begin
            phase_next = rbs_pkg::PH_ONEA;
          end
        end else if (b) begin
          first_time_next = t;
          phase_next      = rbs_pkg::PH_ZEROB;
          zero_count_next = 6'd0;
        end else begin
          phase_next = rbs_pkg::PH_ONEA;
        end
      end
      rbs_pkg::PH_ZEROB, rbs_pkg::PH_ONEB: begin
        if (phase == rbs_pkg::PH_ZEROB && !run_met) begin
          zero_count_next = zc_new;
          if (zc_new >= cfg.zero_run_length) begin
            phase_next = rbs_pkg::PH_ONEB;
          end
        end else if (b) begin
          res_next.round_trip_valid = 1'b1;
          res_next.round_trip       = t - first_time;
          phase_next                = rbs_pkg::PH_DONE;
        end else begin
          phase_next = rbs_pkg::PH_ONEB;
        end
      end
      default: begin
        phase_next = rbs_pkg::PH_DONE;
      end
    endcase

    res_next.phase = phase_next;
    priority if (phase_next >= rbs_pkg::PH_ZEROB) begin
      res_next.tx_stage = rbs_pkg::STAGE_REVERSED;
    end else if (phase_next >= rbs_pkg::PH_ZEROA) begin
      res_next.tx_stage = rbs_pkg::STAGE_ACKED;
    end else begin
      res_next.tx_stage = rbs_pkg::STAGE_INITIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rbs_pkg::PH_HUNT;
      sync_shift  <= rbs_pkg::SYNC_SHIFT_RESET;
      frame_index <= 6'd0;
      ack_latch   <= 1'b0;
      zero_count  <= 6'd0;
      first_time  <= '0;
    end else if (pop) begin
      phase       <= phase_next;
      sync_shift  <= sync_shift_next;
      frame_index <= frame_index_next;
      ack_latch   <= ack_latch_next;
      zero_count  <= zero_count_next;
      first_time  <= first_time_next;
    end
  end

  // Output register: load on pop, drop valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res_next;
    end
  end

endmodule

// ===== rtl/ranging_bit_sequencer_core.sv =====
// Ranging bit sequencer. One input beat carries a sliced decision and its
// sample time; one output beat comes back for every input beat, in order.
// The output beat holds the differentially decoded bit, the sequence phase
// (hunt, frame, zeros A, one A, zeros B, one B, done), the transmitter
// stage, frame end with its ack, and the reversal-to-reversal sample time.
// Channels: in_valid/in_ready and out_valid/out_ready, beat moves when both
// are high. Registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no beat is in flight, which the
// block does not enforce; they act from the next beat on. An accepted
// beat passes through the queue and then the output register.
// Throughput: one beat per cycle while the receiver keeps out_ready high.
// A stalled receiver holds the output register; the two-entry queue keeps
// taking beats until it fills, then in_ready drops.
// Reset (rst, synchronous) empties the queue, clears the output valid, and
// returns to the hunt with the registers at their defaults.
// Depends on rbs_pkg, rbs_front, rbs_queue, rbs_seq.
module ranging_bit_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rbs_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [rbs_pkg::CfgDataWidth-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                raw_decision,
  input  logic [rbs_pkg::TimeWidth-1:0]       sample_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                decoded_bit,
  output logic [2:0]                          phase,
  output logic [1:0]                          tx_stage,
  output logic                                frame_done,
  output logic                                frame_ack,
  output logic                                round_trip_valid,
  output logic [rbs_pkg::TimeWidth-1:0]       round_trip
);

  rbs_pkg::cfg_t    cfg;
  logic             q_full;
  logic             push;
  rbs_pkg::item_t   push_item;
  logic             q_valid;
  rbs_pkg::item_t   q_item;
  logic             pop;
  rbs_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_pattern    <= rbs_pkg::SYNC_PATTERN_RESET;
      cfg.frame_bits      <= rbs_pkg::FRAME_BITS_RESET;
      cfg.ack_position    <= rbs_pkg::ACK_POSITION_RESET;
      cfg.zero_run_length <= rbs_pkg::ZERO_RUN_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbs_pkg::REG_SYNC_PATTERN:    cfg.sync_pattern    <= cfg_data;
        rbs_pkg::REG_FRAME_BITS:      cfg.frame_bits      <= cfg_data[5:0];
        rbs_pkg::REG_ACK_POSITION:    cfg.ack_position    <= cfg_data[5:0];
        rbs_pkg::REG_ZERO_RUN_LENGTH: cfg.zero_run_length <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  rbs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .raw_decision (raw_decision),
    .sample_time  (sample_time),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  rbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  rbs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign decoded_bit      = result.decoded_bit;
  assign phase            = result.phase;
  assign tx_stage         = result.tx_stage;
  assign frame_done       = result.frame_done;
  assign frame_ack        = result.frame_ack;
  assign round_trip_valid = result.round_trip_valid;
  assign round_trip       = result.round_trip;

endmodule

// ===== rtl/rbs_checker.sv =====
// Port-level checks for the ranging bit sequencer, bound to the top level.
// Depends on rbs_pkg and ranging_bit_sequencer_core_defines.svh.
`include "ranging_bit_sequencer_core_defines.svh"

module rbs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [2:0]                          phase,
  input logic [1:0]                          tx_stage,
  input logic                                frame_done,
  input logic                                frame_ack,
  input logic                                round_trip_valid,
  input logic [rbs_pkg::TimeWidth-1:0]       round_trip
);

  `RBS_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "out_valid after reset")

  `RBS_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid && $stable(round_trip) && $stable(phase), "stalled output beat changed")

  `RBS_ASSERT(a_ack_needs_frame, out_valid && frame_ack |-> frame_done, "frame_ack without frame_done")

  `RBS_ASSERT(a_rtt_in_done, out_valid && round_trip_valid |-> phase == 3'(rbs_pkg::PH_DONE) && tx_stage == rbs_pkg::STAGE_REVERSED, "round trip outside done phase")

  `RBS_ASSERT(a_rtt_zero, out_valid && !round_trip_valid |-> round_trip == '0, "round_trip nonzero without valid")

endmodule

bind ranging_bit_sequencer_core rbs_checker u_rbs_checker (.*);

// ===== tb/sv/ranging_bit_sequencer_core_tb.sv =====
// Self-checking testbench for ranging_bit_sequencer_core: sends decision beats,
// predicts every result beat with a behavioral copy of the sequencer and checks it.
// Depends on rbs_pkg and the ranging_bit_sequencer_core RTL.
module ranging_bit_sequencer_core_tb;

  localparam int HALF_PERIOD     = 10;
  localparam int RESET_CYCLES    = 2;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TRAFFIC_ITEMS   = 280;
  localparam int SOLO_IDLE_PCT   = 46;
  localparam int SHARED_IDLE_PCT = 34;
  localparam int REPORT_LIMIT    = 40;

  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SENDER_IDLE,
    TRAFFIC_RECEIVER_STALL,
    TRAFFIC_BOTH
  } traffic_t;

  logic                              clk          = 1'b0;
  logic                              rst          = 1'b1;
  logic                              cfg_we       = 1'b0;
  logic [rbs_pkg::CfgIndexWidth-1:0] cfg_index    = '0;
  logic [rbs_pkg::CfgDataWidth-1:0]  cfg_data     = '0;
  logic                              in_valid     = 1'b0;
  logic                              in_ready;
  logic                              raw_decision = 1'b0;
  logic [rbs_pkg::TimeWidth-1:0]     sample_time  = '0;
  logic                              out_valid;
  logic                              out_ready    = 1'b0;
  logic                              decoded_bit;
  logic [2:0]                        phase;
  logic [1:0]                        tx_stage;
  logic                              frame_done;
  logic                              frame_ack;
  logic                              round_trip_valid;
  logic [rbs_pkg::TimeWidth-1:0]     round_trip;

  // Shadow of the sequencer registers and state
  rbs_pkg::cfg_t cfg = '{sync_pattern: rbs_pkg::SYNC_PATTERN_RESET,
                         frame_bits: rbs_pkg::FRAME_BITS_RESET,
                         ack_position: rbs_pkg::ACK_POSITION_RESET,
                         zero_run_length: rbs_pkg::ZERO_RUN_LENGTH_RESET};
  logic                          last_raw      = 1'b0;
  logic [7:0]                    sync_window   = rbs_pkg::SYNC_SHIFT_RESET;
  rbs_pkg::phase_t               seq_phase     = rbs_pkg::PH_HUNT;
  logic [5:0]                    bit_index     = '0;
  logic                          ack_held      = 1'b0;
  logic [5:0]                    zero_run      = '0;
  logic [rbs_pkg::TimeWidth-1:0] reversal_time = '0;

  rbs_pkg::result_t pending[$];
  int      errors       = 0;
  int      items_sent   = 0;
  int      idle_pct     = 0;
  int      stall_pct    = 0;
  int      quiet_cycles = 0;

  ranging_bit_sequencer_core uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .raw_decision     (raw_decision),
    .sample_time      (sample_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .decoded_bit      (decoded_bit),
    .phase            (phase),
    .tx_stage         (tx_stage),
    .frame_done       (frame_done),
    .frame_ack        (frame_ack),
    .round_trip_valid (round_trip_valid),
    .round_trip       (round_trip)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic void open_frame();
    seq_phase = rbs_pkg::PH_FRAME;
    bit_index = '0;
    ack_held  = 1'b0;
  endfunction

  function automatic logic zero_run_met(input logic b);
    if (b) zero_run = '0;
    else if (zero_run < rbs_pkg::ZERO_COUNT_MAX) zero_run = zero_run + 6'd1;
    return zero_run >= cfg.zero_run_length;
  endfunction

  // Advance the shadow sequencer by one decision and return the result beat it causes
  function automatic rbs_pkg::result_t step_sequencer(
      input logic raw, input logic [rbs_pkg::TimeWidth-1:0] stamp);
    rbs_pkg::result_t r;
    logic    b;
    logic    take_frame;
    logic    take_one_a;
    logic    take_one_b;
    b          = raw ^ last_raw;
    last_raw   = raw;
    r          = '0;
    take_frame = 1'b0;
    take_one_a = 1'b0;
    take_one_b = 1'b0;
    case (seq_phase)
      rbs_pkg::PH_HUNT: begin
        if (sync_window == cfg.sync_pattern) begin
          // sync already in the window: this bit is frame bit 0
          open_frame();
          take_frame = 1'b1;
        end else begin
          sync_window = {sync_window[6:0], b};
          if (sync_window == cfg.sync_pattern) open_frame();
        end
      end
      rbs_pkg::PH_FRAME: take_frame = 1'b1;
      rbs_pkg::PH_ZEROA: begin
        if (zero_run < cfg.zero_run_length) begin
          if (zero_run_met(b)) seq_phase = rbs_pkg::PH_ONEA;
        end else begin
          take_one_a = 1'b1;
        end
      end
      rbs_pkg::PH_ONEA: take_one_a = 1'b1;
      rbs_pkg::PH_ZEROB: begin
        if (zero_run < cfg.zero_run_length) begin
          if (zero_run_met(b)) seq_phase = rbs_pkg::PH_ONEB;
        end else begin
          take_one_b = 1'b1;
        end
      end
      rbs_pkg::PH_ONEB: take_one_b = 1'b1;
      default: seq_phase = rbs_pkg::PH_DONE;
    endcase

    if (take_frame) begin
      if (bit_index == cfg.ack_position) ack_held = b;
      bit_index = bit_index + 6'd1;
      if (bit_index >= cfg.frame_bits) begin
        r.frame_done = 1'b1;
        r.frame_ack  = ack_held;
        if (ack_held) begin
          seq_phase = rbs_pkg::PH_ZEROA;
          zero_run  = '0;
        end else begin
          seq_phase   = rbs_pkg::PH_HUNT;
          sync_window = rbs_pkg::SYNC_SHIFT_RESET;
        end
      end
    end
    if (take_one_a) begin
      if (b) begin
        reversal_time = stamp;
        seq_phase     = rbs_pkg::PH_ZEROB;
        zero_run      = '0;
      end else begin
        seq_phase = rbs_pkg::PH_ONEA;
      end
    end
    if (take_one_b) begin
      if (b) begin
        r.round_trip_valid = 1'b1;
        r.round_trip       = stamp - reversal_time;
        seq_phase          = rbs_pkg::PH_DONE;
      end else begin
        seq_phase = rbs_pkg::PH_ONEB;
      end
    end

    r.decoded_bit = b;
    r.phase       = seq_phase;
    if (seq_phase >= rbs_pkg::PH_ZEROB) r.tx_stage = rbs_pkg::STAGE_REVERSED;
    else if (seq_phase >= rbs_pkg::PH_ZEROA) r.tx_stage = rbs_pkg::STAGE_ACKED;
    else r.tx_stage = rbs_pkg::STAGE_INITIAL;
    return r;
  endfunction

  // True when the next decoded bit lands on the ack slot of a frame
  function automatic logic ack_bit_next();
    return (seq_phase == rbs_pkg::PH_FRAME && bit_index == cfg.ack_position) ||
           (seq_phase == rbs_pkg::PH_HUNT && sync_window == cfg.sync_pattern &&
            cfg.ack_position == 6'd0);
  endfunction

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_FREE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      TRAFFIC_SENDER_IDLE: begin
        idle_pct  = SOLO_IDLE_PCT;
        stall_pct = 0;
      end
      TRAFFIC_RECEIVER_STALL: begin
        idle_pct  = 0;
        stall_pct = SOLO_IDLE_PCT;
      end
      default: begin
        idle_pct  = SHARED_IDLE_PCT;
        stall_pct = SHARED_IDLE_PCT;
      end
    endcase
  endtask

  task automatic send_decision(input logic raw, input logic [rbs_pkg::TimeWidth-1:0] stamp);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1'b1;
    raw_decision <= raw;
    sample_time  <= stamp;
    do @(posedge clk); while (!in_ready);
    pending.push_back(step_sequencer(raw, stamp));
    items_sent++;
  endtask

  // Encode a decoded bit differentially against the last raw decision on the line
  task automatic send_bit(input logic b, input logic [rbs_pkg::TimeWidth-1:0] stamp);
    send_decision(b ^ last_raw, stamp);
  endtask

  // Random bit, held at 0 on an ack slot so the hunt keeps restarting
  task automatic send_noise_bit();
    send_bit(ack_bit_next() ? 1'b0 : 1'($urandom_range(1)), $urandom);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic write_reg(input logic [rbs_pkg::CfgIndexWidth-1:0] index,
                           input logic [rbs_pkg::CfgDataWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      rbs_pkg::REG_SYNC_PATTERN:    cfg.sync_pattern    = value;
      rbs_pkg::REG_FRAME_BITS:      cfg.frame_bits      = value[5:0];
      rbs_pkg::REG_ACK_POSITION:    cfg.ack_position    = value[5:0];
      rbs_pkg::REG_ZERO_RUN_LENGTH: cfg.zero_run_length = value[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain, then load a random setting with the extremes favored
  task automatic retune();
    logic [5:0] frame_len;
    logic [5:0] ack_pos;
    drain();
    case ($urandom_range(3))
      0: write_reg(rbs_pkg::REG_SYNC_PATTERN, 8'hFF);
      1: write_reg(rbs_pkg::REG_SYNC_PATTERN, 8'h00);
      default: write_reg(rbs_pkg::REG_SYNC_PATTERN, 8'($urandom));
    endcase
    case ($urandom_range(7))
      0: frame_len = 6'd0;
      1: frame_len = 6'd63;
      2: frame_len = 6'd1;
      default: frame_len = 6'($urandom_range(2, 16));
    endcase
    case ($urandom_range(4))
      0: ack_pos = 6'd62;
      1: ack_pos = 6'd0;
      default: ack_pos = (frame_len == 6'd0) ? 6'd0 : 6'($urandom_range(frame_len - 1));
    endcase
    write_reg(rbs_pkg::REG_FRAME_BITS, {2'b00, frame_len});
    write_reg(rbs_pkg::REG_ACK_POSITION, {2'b00, ack_pos});
    case ($urandom_range(3))
      0: write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, 8'd0);
      1: write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, 8'd1);
      2: write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, {2'b00, rbs_pkg::ZERO_COUNT_MAX});
      default: write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, 8'($urandom_range(1, 40)));
    endcase
  endtask

  // Close any open frame, then shift in the sync byte MSB first until a frame opens
  task automatic send_sync();
    while (seq_phase == rbs_pkg::PH_FRAME) send_noise_bit();
    for (int i = 7; i >= 0 && seq_phase == rbs_pkg::PH_HUNT &&
         sync_window != cfg.sync_pattern; i--)
      send_bit(cfg.sync_pattern[i], $urandom);
  endtask

  task automatic send_frame(input logic ack_value);
    logic frame_open;
    send_sync();
    frame_open = 1'b1;
    while (frame_open) begin
      send_bit(ack_bit_next() ? ack_value : 1'($urandom_range(1)), $urandom);
      frame_open = (seq_phase == rbs_pkg::PH_FRAME);
    end
  endtask

  task automatic test_frame_corners();
    write_reg(rbs_pkg::REG_SYNC_PATTERN, 8'hFF);
    write_reg(rbs_pkg::REG_FRAME_BITS, 8'd0);
    write_reg(rbs_pkg::REG_ACK_POSITION, 8'd0);
    // sync matches straight out of reset; each bit is a whole zero-length frame
    send_bit(1'b0, '0);
    send_bit(1'b0, '1);
    drain();
    write_reg(rbs_pkg::REG_FRAME_BITS, 8'd2);
    write_reg(rbs_pkg::REG_ACK_POSITION, 8'd62);
    // ack slot beyond the frame end: ack reads 0 and the hunt restarts
    send_bit(1'b1, $urandom);
    send_bit(1'b1, $urandom);
    send_bit(1'b0, $urandom);
    send_bit(1'b1, $urandom);
    drain();
    write_reg(rbs_pkg::REG_SYNC_PATTERN, rbs_pkg::SYNC_PATTERN_RESET);
    write_reg(rbs_pkg::REG_FRAME_BITS, 8'd3);
    write_reg(rbs_pkg::REG_ACK_POSITION, 8'd1);
    send_frame(1'b0);
  endtask

  task automatic test_frame_traffic(input traffic_t mode);
    int stop_at;
    int cut;
    set_traffic(mode);
    stop_at = items_sent + TRAFFIC_ITEMS;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0: retune();
        1, 2: repeat ($urandom_range(1, 12)) send_noise_bit();
        3: begin
          // broken sync: part of the byte, then a flipped bit
          cut = $urandom_range(1, 7);
          for (int i = 7; i > 7 - cut && seq_phase == rbs_pkg::PH_HUNT; i--)
            send_bit(cfg.sync_pattern[i], $urandom);
          if (seq_phase == rbs_pkg::PH_HUNT && !ack_bit_next())
            send_bit(~cfg.sync_pattern[7 - cut], $urandom);
        end
        default: send_frame(1'b0);
      endcase
    end
  endtask

  // Shrink the frame length under a frame in progress
  task automatic test_resize_mid_frame();
    repeat (3) begin
      drain();
      write_reg(rbs_pkg::REG_FRAME_BITS, 8'd40);
      write_reg(rbs_pkg::REG_ACK_POSITION, 8'($urandom_range(39)));
      send_sync();
      repeat ($urandom_range(1, 30)) send_noise_bit();
      drain();
      write_reg(rbs_pkg::REG_FRAME_BITS, 8'($urandom_range(bit_index)));
      send_noise_bit();
    end
  endtask

  task automatic test_round_trip();
    logic [5:0] frame_len;
    int         run_len;
    set_traffic(TRAFFIC_BOTH);
    drain();
    frame_len = 6'($urandom_range(1, 20));
    write_reg(rbs_pkg::REG_SYNC_PATTERN, 8'($urandom));
    write_reg(rbs_pkg::REG_FRAME_BITS, {2'b00, frame_len});
    write_reg(rbs_pkg::REG_ACK_POSITION, 8'($urandom_range(frame_len - 1)));
    write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, {2'b00, rbs_pkg::ZERO_COUNT_MAX});
    send_frame(1'b1);

    // first reversal: interrupted zero runs, then the full run and a one
    repeat (4) begin
      repeat ($urandom_range(0, 40)) send_bit(1'b0, $urandom);
      send_bit(1'b1, $urandom);
    end
    repeat (rbs_pkg::ZERO_COUNT_MAX) send_bit(1'b0, $urandom);
    repeat ($urandom_range(0, 10)) send_bit(1'b0, $urandom);
    send_bit(1'b1, 32'hFFFF_FF00 + $urandom_range(255));

    set_traffic(TRAFFIC_FREE);
    drain();
    run_len = $urandom_range(5, 20);
    write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, 8'(run_len));
    repeat (3) begin
      repeat ($urandom_range(0, run_len - 1)) send_bit(1'b0, $urandom);
      send_bit(1'b1, $urandom);
    end
    repeat ($urandom_range(1, run_len - 1)) send_bit(1'b0, $urandom);
    // drop the run length under a partial run: the next bit waits for the one
    drain();
    write_reg(rbs_pkg::REG_ZERO_RUN_LENGTH, 8'd0);
    send_bit(1'b0, $urandom);
    repeat ($urandom_range(0, 5)) send_bit(1'b0, $urandom);
    // second reversal after the time stamp wrapped
    send_bit(1'b1, 32'($urandom_range(255)));
  endtask

  task automatic test_done_hold();
    set_traffic(TRAFFIC_SENDER_IDLE);
    repeat (3) begin
      retune();
      repeat (50) send_noise_bit();
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors < REPORT_LIMIT)
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rbs_pkg::result_t want;
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (out_valid && out_ready) begin
        if (pending.size() == 0) begin
          errors++;
          if (errors < REPORT_LIMIT)
            $display("%0t: result beat with nothing expected", $time);
        end else begin
          want = pending.pop_front();
          check_field("decoded_bit", 32'(want.decoded_bit), 32'(decoded_bit));
          check_field("phase", 32'(want.phase), 32'(phase));
          check_field("tx_stage", 32'(want.tx_stage), 32'(tx_stage));
          check_field("frame_done", 32'(want.frame_done), 32'(frame_done));
          check_field("frame_ack", 32'(want.frame_ack), 32'(frame_ack));
          check_field("round_trip_valid", 32'(want.round_trip_valid),
                      32'(round_trip_valid));
          check_field("round_trip", want.round_trip, round_trip);
        end
      end
    end
  end

  // Hold a count of cycles with no beat and no register write
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_frame_corners();
    test_frame_traffic(TRAFFIC_FREE);
    test_resize_mid_frame();
    test_frame_traffic(TRAFFIC_SENDER_IDLE);
    test_resize_mid_frame();
    test_frame_traffic(TRAFFIC_RECEIVER_STALL);
    test_resize_mid_frame();
    test_frame_traffic(TRAFFIC_BOTH);
    test_round_trip();
    test_done_hold();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
